// ----- src/lqlt_pkg.sv -----
package lqlt_pkg;

    // Width of a device's running total over the window.
    localparam int unsigned TOTAL_W = 11;

    // Threshold after reset.
    localparam logic [7:0] THRESHOLD_RESET = 8'h50;

    // Fraction bits of the reciprocal used for the division by the window length.
    localparam int unsigned RECIP_SHIFT = 14;
    localparam int unsigned RECIP_W     = 15;

    typedef enum logic [1:0] {
        KIND_REPORT  = 2'd0,
        KIND_SILENCE = 2'd1,
        KIND_TOGGLE  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        LAMP_NONE  = 3'd0,
        LAMP_BLUE  = 3'd1,
        LAMP_RED   = 3'd2,
        LAMP_GREEN = 3'd3,
        LAMP_WHITE = 3'd4,
        LAMP_OFF   = 3'd5
    } lamp_t;

    typedef struct packed {
        logic sounding;
        logic silenced;
        logic tracking;
    } flags_t;

endpackage

// ----- src/lqlt_ram.sv -----
module lqlt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ----- src/lqlt_update.sv -----
module lqlt_update
    import lqlt_pkg::*;
#(
    parameter int unsigned WINDOW = 6,
    parameter int unsigned POS_W  = 3,
    parameter int unsigned CNT_W  = 5
) (
    input  kind_t                 kind,
    input  logic                  in_range,
    input  logic [7:0]            quality,
    input  logic [7:0]            threshold,
    input  flags_t                flags,
    input  logic [CNT_W-1:0]      lost_count,
    input  logic [TOTAL_W-1:0]    rec_total,
    input  logic [POS_W-1:0]      rec_pos,
    input  logic                  rec_filled,
    input  logic                  rec_lost,
    input  logic [WINDOW*8-1:0]   row,
    output logic                  wr_en,
    output logic [TOTAL_W-1:0]    new_total,
    output logic [POS_W-1:0]      new_pos,
    output logic                  new_filled,
    output logic                  new_lost,
    output logic [WINDOW*8-1:0]   new_row,
    output flags_t                flags_next,
    output logic [CNT_W-1:0]      count_next,
    output logic [7:0]            average,
    output logic                  dev_lost,
    output lamp_t                 lamp
);

    localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** RECIP_SHIFT) + WINDOW - 1) / WINDOW);

    logic [POS_W-1:0]           pos_eff;
    logic                       filled_eff;
    logic [IDX_W-1:0]           idx;
    logic [7:0]                 oldest;
    logic [TOTAL_W-1:0]         total_sub;
    logic [TOTAL_W+RECIP_W-1:0] product;
    logic [7:0]                 avg_new;

    // Position wrap, ring replacement and the new total.
    always_comb
    begin
        pos_eff    = rec_pos;
        filled_eff = rec_filled;
        if (rec_pos >= POS_W'(WINDOW))
        begin
            pos_eff    = '0;
            filled_eff = 1'b1;
        end
        idx       = pos_eff[IDX_W-1:0];
        oldest    = row[8*idx +: 8];
        total_sub = filled_eff ? (rec_total - {3'b000, oldest}) : rec_total;
        new_total = total_sub + {3'b000, quality};
        new_pos   = pos_eff + POS_W'(1);
        new_filled = filled_eff;
        new_row   = row;
        new_row[8*idx +: 8] = quality;
    end

    // The reciprocal is rounded up, which keeps the quotient exact for every 11-bit total.
    assign product = (TOTAL_W + RECIP_W)'(new_total) * (TOTAL_W + RECIP_W)'(RECIP);
    assign avg_new = product[RECIP_SHIFT +: 8];

    always_comb
    begin
        flags_next = flags;
        count_next = lost_count;
        wr_en      = 1'b0;
        new_lost   = rec_lost;
        average    = '0;
        dev_lost   = 1'b0;
        lamp       = LAMP_NONE;
        unique case (kind)
            KIND_REPORT:
            begin
                if (in_range)
                begin
                    dev_lost = rec_lost;
                    if (flags.tracking && (quality != 8'd0))
                    begin
                        wr_en   = 1'b1;
                        average = avg_new;
                        if (!rec_lost)
                        begin
                            flags_next.silenced = 1'b0;
                            if (!flags.sounding)
                            begin
                                lamp = LAMP_BLUE;
                            end
                            if (filled_eff && (avg_new < threshold))
                            begin
                                new_lost   = 1'b1;
                                count_next = lost_count + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            if (!flags.sounding)
                            begin
                                lamp                = LAMP_RED;
                                flags_next.sounding = 1'b1;
                            end
                            if (avg_new > threshold)
                            begin
                                new_lost = 1'b0;
                                if (lost_count != '0)
                                begin
                                    count_next = lost_count - CNT_W'(1);
                                end
                            end
                            if (count_next == '0)
                            begin
                                flags_next.sounding = 1'b0;
                            end
                        end
                        dev_lost = new_lost;
                    end
                end
            end
            KIND_SILENCE:
            begin
                if (flags.sounding)
                begin
                    lamp                = LAMP_GREEN;
                    flags_next.silenced = 1'b1;
                end
            end
            KIND_TOGGLE:
            begin
                flags_next.tracking = !flags.tracking;
                lamp = flags.tracking ? LAMP_WHITE : LAMP_OFF;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- src/link_quality_loss_tracker_core.sv -----
// Link quality loss tracker. Each accepted beat is a quality report, a silence press or an
// enable toggle; each gives exactly one result beat, in order. One beat is taken per cycle
// unless a result stall holds it. The read stage fetches the device's record and sample
// ring row from two single-port-read memories; the update stage updates them, writes them
// back and loads the output register. A directly following report for the same device is
// served from a forwarding register, so there is no interlock. Per-device valid bits make
// an unwritten record read as zero, so no clearing pass follows reset. The user must write
// the threshold register via the cfg channel only while idle; the block does not enforce it.
module link_quality_loss_tracker_core
    import lqlt_pkg::*;
#(
    parameter int unsigned DEVICES = 16,
    parameter int unsigned WINDOW  = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       report_valid,
    output logic       report_stall,
    input  logic [1:0] kind,
    input  logic [3:0] device,
    input  logic [7:0] quality,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] device_average,
    output logic       device_lost,
    output logic       alarm_on,
    output logic       alarm_quiet,
    output logic       tracking_on,
    output logic [2:0] lamp_color
);

    localparam int unsigned DEV_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int unsigned POS_W = $clog2(WINDOW + 1);
    localparam int unsigned CNT_W = $clog2(DEVICES + 1);
    localparam int unsigned ROW_W = WINDOW * 8;
    localparam int unsigned REC_W = TOTAL_W + POS_W + 2;

    // Record layout: lost, filled, position, total.
    localparam int unsigned POS_LSB    = TOTAL_W;
    localparam int unsigned FILLED_BIT = TOTAL_W + POS_W;
    localparam int unsigned LOST_BIT   = TOTAL_W + POS_W + 1;

    logic [7:0]         threshold_reg;
    flags_t             flags_reg;
    flags_t             flags_next;
    logic [CNT_W-1:0]   lost_count_reg;
    logic [CNT_W-1:0]   count_next;

    logic               accept;
    logic [DEV_W+3:0]   device_ext;
    logic [DEV_W-1:0]   dev_addr;

    logic               s1_vld_reg;
    kind_t              s1_kind_reg;
    logic [DEV_W-1:0]   s1_dev_reg;
    logic               s1_in_range_reg;
    logic [7:0]         s1_quality_reg;
    logic               s1_adv;

    logic [DEVICES-1:0] dev_valid_reg;
    logic               rd_valid_reg;
    logic [REC_W-1:0]   rec_rd;
    logic [ROW_W-1:0]   row_rd;

    logic               fwd_vld_reg;
    logic [DEV_W-1:0]   fwd_dev_reg;
    logic [REC_W-1:0]   fwd_rec_reg;
    logic [ROW_W-1:0]   fwd_row_reg;

    logic               use_fwd;
    logic [REC_W-1:0]   rec_cur;
    logic [ROW_W-1:0]   row_cur;

    logic               upd_wr_en;
    logic [TOTAL_W-1:0] new_total;
    logic [POS_W-1:0]   new_pos;
    logic               new_filled;
    logic               new_lost;
    logic [ROW_W-1:0]   new_row;
    logic [REC_W-1:0]   rec_wr;
    logic               ram_wr_en;
    logic [7:0]         upd_average;
    logic               upd_dev_lost;
    lamp_t              upd_lamp;

    logic               result_valid_reg;
    logic [7:0]         average_reg;
    logic               dev_lost_reg;
    logic               alarm_on_reg;
    logic               alarm_quiet_reg;
    logic               tracking_on_reg;
    lamp_t              lamp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    // The output register frees the update stage as soon as its beat is taken.
    assign s1_adv       = s1_vld_reg && (!result_valid_reg || !result_stall);
    assign report_stall = s1_vld_reg && !s1_adv;
    assign accept       = report_valid && !report_stall;

    assign device_ext = {{DEV_W{1'b0}}, device};
    assign dev_addr   = device_ext[DEV_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_vld_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg     <= kind_t'(kind);
            s1_dev_reg      <= dev_addr;
            s1_in_range_reg <= device_ext < (DEV_W + 4)'(DEVICES);
            s1_quality_reg  <= quality;
            rd_valid_reg    <= dev_valid_reg[dev_addr];
        end
    end

    lqlt_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEVICES)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (s1_dev_reg),
        .wr_data (rec_wr),
        .rd_en   (accept),
        .rd_addr (dev_addr),
        .rd_data (rec_rd)
    );

    lqlt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEVICES)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (s1_dev_reg),
        .wr_data (new_row),
        .rd_en   (accept),
        .rd_addr (dev_addr),
        .rd_data (row_rd)
    );

    // The memory returns old data when a read meets a write to the same entry; the
    // forwarding register holds the latest write, which is then the current value.
    assign use_fwd = fwd_vld_reg && (fwd_dev_reg == s1_dev_reg);
    assign rec_cur = use_fwd ? fwd_rec_reg : (rd_valid_reg ? rec_rd : '0);
    assign row_cur = use_fwd ? fwd_row_reg : row_rd;

    lqlt_update #(
        .WINDOW (WINDOW),
        .POS_W  (POS_W),
        .CNT_W  (CNT_W)
    ) u_update (
        .kind       (s1_kind_reg),
        .in_range   (s1_in_range_reg),
        .quality    (s1_quality_reg),
        .threshold  (threshold_reg),
        .flags      (flags_reg),
        .lost_count (lost_count_reg),
        .rec_total  (rec_cur[TOTAL_W-1:0]),
        .rec_pos    (rec_cur[POS_LSB +: POS_W]),
        .rec_filled (rec_cur[FILLED_BIT]),
        .rec_lost   (rec_cur[LOST_BIT]),
        .row        (row_cur),
        .wr_en      (upd_wr_en),
        .new_total  (new_total),
        .new_pos    (new_pos),
        .new_filled (new_filled),
        .new_lost   (new_lost),
        .new_row    (new_row),
        .flags_next (flags_next),
        .count_next (count_next),
        .average    (upd_average),
        .dev_lost   (upd_dev_lost),
        .lamp       (upd_lamp)
    );

    assign rec_wr    = {new_lost, new_filled, new_pos, new_total};
    assign ram_wr_en = s1_adv && upd_wr_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_valid_reg  <= '0;
            fwd_vld_reg    <= 1'b0;
            flags_reg      <= '{sounding: 1'b0, silenced: 1'b0, tracking: 1'b1};
            lost_count_reg <= '0;
        end
        else
        begin
            if (ram_wr_en)
            begin
                dev_valid_reg[s1_dev_reg] <= 1'b1;
                fwd_vld_reg               <= 1'b1;
            end
            if (s1_adv)
            begin
                flags_reg      <= flags_next;
                lost_count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_wr_en)
        begin
            fwd_dev_reg <= s1_dev_reg;
            fwd_rec_reg <= rec_wr;
            fwd_row_reg <= new_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            average_reg     <= upd_average;
            dev_lost_reg    <= upd_dev_lost;
            alarm_on_reg    <= flags_next.sounding;
            alarm_quiet_reg <= flags_next.silenced;
            tracking_on_reg <= flags_next.tracking;
            lamp_reg        <= upd_lamp;
        end
    end

    assign result_valid   = result_valid_reg;
    assign device_average = average_reg;
    assign device_lost    = dev_lost_reg;
    assign alarm_on       = alarm_on_reg;
    assign alarm_quiet    = alarm_quiet_reg;
    assign tracking_on    = tracking_on_reg;
    assign lamp_color     = lamp_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        lost_count_reg <= CNT_W'(DEVICES))
        else $error("lost device count exceeds the number of devices");

    a_alarm_needs_lost: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.sounding |-> (lost_count_reg != '0))
        else $error("alarm sounding with no lost device");

    a_update_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> result_valid_reg)
        else $error("update stage advanced without loading a result");
`endif

endmodule

// ----- dv/tb_link_quality_loss_tracker_core.sv -----
`timescale 1ns / 1ps

module tb_link_quality_loss_tracker_core;
    import lqlt_pkg::*;

    localparam int DEVICES     = 16;
    localparam int WINDOW      = 6;
    localparam int CLK_PERIOD  = 10;
    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 8;

    // The package names three kinds; the fourth code is driven too and must change nothing.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] average;
        logic       lost;
        logic       sounding;
        logic       silenced;
        logic       tracking;
        lamp_t      lamp;
    } tracker_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'd0;
    logic       report_valid = 1'b0;
    logic       report_stall;
    logic [1:0] kind = 2'd0;
    logic [3:0] device = 4'd0;
    logic [7:0] quality = 8'd0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [7:0] device_average;
    logic       device_lost;
    logic       alarm_on;
    logic       alarm_quiet;
    logic       tracking_on;
    logic [2:0] lamp_color;

    // Mirror of the tracker's state, advanced once per accepted beat.
    logic [7:0]  ring_m [DEVICES][WINDOW];
    logic [10:0] total_m [DEVICES];
    int          pos_m [DEVICES];
    bit          filled_m [DEVICES];
    logic [7:0]  avg_m [DEVICES];
    bit          lost_m [DEVICES];
    int          lost_count_m;
    bit          sounding_m;
    bit          silenced_m;
    bit          tracking_m;
    logic [7:0]  threshold_m;

    tracker_beat_t outcomes_due[$];
    tracker_beat_t due_beat;
    int            mismatch_count = 0;
    int            cycles_without_beat = 0;
    bit            tx_idle_en = 1'b1;
    bit            rx_idle_en = 1'b1;
    int            hold_off_len = 0;

    link_quality_loss_tracker_core #(
        .DEVICES (DEVICES),
        .WINDOW  (WINDOW)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .report_valid   (report_valid),
        .report_stall   (report_stall),
        .kind           (kind),
        .device         (device),
        .quality        (quality),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .device_average (device_average),
        .device_lost    (device_lost),
        .alarm_on       (alarm_on),
        .alarm_quiet    (alarm_quiet),
        .tracking_on    (tracking_on),
        .lamp_color     (lamp_color)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void reset_tracker_model();
        for (int d = 0; d < DEVICES; d++)
        begin
            for (int s = 0; s < WINDOW; s++)
                ring_m[d][s] = 8'd0;
            total_m[d]  = '0;
            pos_m[d]    = 0;
            filled_m[d] = 1'b0;
            avg_m[d]    = 8'd0;
            lost_m[d]   = 1'b0;
        end
        lost_count_m = 0;
        sounding_m   = 1'b0;
        silenced_m   = 1'b0;
        tracking_m   = 1'b1;
        threshold_m  = THRESHOLD_RESET;
    endfunction

    function automatic tracker_beat_t predict_tracker_step(input logic [1:0] k,
                                                           input logic [3:0] d,
                                                           input logic [7:0] q);
        tracker_beat_t r;
        int            slot;
        logic [7:0]    oldest;
        r      = '0;
        r.lamp = LAMP_NONE;
        case (k)
            KIND_REPORT:
            begin
                if (tracking_m && q != 8'd0)
                begin
                    slot = pos_m[d];
                    if (slot >= WINDOW)
                    begin
                        slot        = 0;
                        filled_m[d] = 1'b1;
                    end
                    oldest         = ring_m[d][slot];
                    ring_m[d][slot] = q;
                    // The oldest sample only leaves the total once the window has wrapped.
                    if (filled_m[d])
                        total_m[d] = total_m[d] - oldest;
                    total_m[d] = total_m[d] + q;
                    avg_m[d]   = 8'(total_m[d] / WINDOW);
                    pos_m[d]   = slot + 1;
                    if (!lost_m[d])
                    begin
                        silenced_m = 1'b0;
                        if (!sounding_m)
                            r.lamp = LAMP_BLUE;
                        if (filled_m[d] && avg_m[d] < threshold_m)
                        begin
                            lost_m[d] = 1'b1;
                            lost_count_m++;
                        end
                    end
                    else
                    begin
                        if (!sounding_m)
                        begin
                            r.lamp     = LAMP_RED;
                            sounding_m = 1'b1;
                        end
                        if (avg_m[d] > threshold_m)
                        begin
                            lost_m[d] = 1'b0;
                            if (lost_count_m > 0)
                                lost_count_m--;
                        end
                        if (lost_count_m == 0)
                            sounding_m = 1'b0;
                    end
                    r.average = avg_m[d];
                end
                r.lost = lost_m[d];
            end
            KIND_SILENCE:
            begin
                if (sounding_m)
                begin
                    r.lamp     = LAMP_GREEN;
                    silenced_m = 1'b1;
                end
            end
            KIND_TOGGLE:
            begin
                tracking_m = !tracking_m;
                r.lamp     = tracking_m ? LAMP_OFF : LAMP_WHITE;
            end
            default:
            begin
            end
        endcase
        r.sounding = sounding_m;
        r.silenced = silenced_m;
        r.tracking = tracking_m;
        return r;
    endfunction

    task automatic note_mismatch(input string detail);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, detail);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected %0d, got %0d", field, want, got));
    endtask

    // Sender. Called at a rising edge; returns at the edge where the beat was taken.
    task automatic offer_beat(input logic [1:0] k, input logic [3:0] d, input logic [7:0] q);
        while (tx_idle_en && $urandom_range(0, 99) < 36)
        begin
            report_valid <= 1'b0;
            @(posedge clk);
        end
        report_valid <= 1'b1;
        kind         <= k;
        device       <= d;
        quality      <= q;
        @(posedge clk);
        while (report_stall)
            @(posedge clk);
        outcomes_due.push_back(predict_tracker_step(k, d, q));
    endtask

    task automatic write_threshold(input logic [7:0] value);
        report_valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        threshold_m = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] near_threshold_quality();
        int v;
        if ($urandom_range(0, 99) < 25)
            return 8'($urandom_range(1, 255));
        v = int'(threshold_m) + int'($urandom_range(0, 80)) - 40;
        if (v < 1)
            v = 1;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // Receiver: random stalls, or a long hold-off when one is asked for.
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                n            = hold_off_len;
                hold_off_len = 0;
                result_stall <= 1'b1;
                repeat (n - 1) @(posedge clk);
            end
            else
            begin
                result_stall <= rx_idle_en && ($urandom_range(0, 99) < 36);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (outcomes_due.size() == 0)
            begin
                note_mismatch("result beat with no report pending");
            end
            else
            begin
                due_beat = outcomes_due.pop_front();
                check_field("device_average", due_beat.average, device_average);
                check_field("device_lost", due_beat.lost, device_lost);
                check_field("alarm_on", due_beat.sounding, alarm_on);
                check_field("alarm_quiet", due_beat.silenced, alarm_quiet);
                check_field("tracking_on", due_beat.tracking, tracking_on);
                check_field("lamp_color", due_beat.lamp, lamp_color);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (report_valid && !report_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            cycles_without_beat <= 0;
        else
            cycles_without_beat <= cycles_without_beat + 1;
        if (cycles_without_beat >= STUCK_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_special_kinds();
        offer_beat(KIND_SILENCE, 4'd0, 8'd0);
        offer_beat(KIND_SPARE, 4'hF, 8'hFF);
        offer_beat(KIND_REPORT, 4'd5, 8'd0);
        offer_beat(KIND_TOGGLE, 4'd0, 8'd0);
        offer_beat(KIND_REPORT, 4'd3, 8'd200);
        offer_beat(KIND_SILENCE, 4'd7, 8'd12);
        offer_beat(KIND_TOGGLE, 4'hA, 8'h55);
        offer_beat(KIND_REPORT, 4'd0, 8'hFF);
        offer_beat(KIND_REPORT, 4'hF, 8'd1);
    endtask

    // Fill one device with poor samples until it is lost, sound and silence the alarm,
    // then bring it back with strong samples.
    task automatic test_loss_and_recovery();
        for (int i = 0; i < WINDOW + 1; i++)
            offer_beat(KIND_REPORT, 4'd9, 8'd20);
        offer_beat(KIND_REPORT, 4'd9, 8'd20);
        offer_beat(KIND_SILENCE, 4'd0, 8'd0);
        for (int i = 0; i < 4; i++)
            offer_beat(KIND_REPORT, 4'd9, 8'd255);
    endtask

    task automatic test_backpressure();
        tx_idle_en   = 1'b0;
        hold_off_len = HOLD_CYCLES;
        for (int i = 0; i < 30; i++)
            offer_beat(KIND_REPORT, 4'($urandom_range(0, 3)), near_threshold_quality());
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [3:0] pool [3];
        logic [7:0] level;
        int         roll;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: level = 8'd255;
                1: level = 8'd0;
                4: level = THRESHOLD_RESET;
                default: level = 8'($urandom_range(30, 220));
            endcase
            write_threshold(level);
            tx_idle_en = (phase != 2);
            rx_idle_en = (phase != 2);
            for (int p = 0; p < 3; p++)
                pool[p] = 4'($urandom_range(0, DEVICES - 1));
            for (int i = 0; i < 70; i++)
            begin
                roll = $urandom_range(0, 99);
                // Do not leave tracking off for long, or most reports would be ignored.
                if (!tracking_m && $urandom_range(0, 3) == 0)
                    offer_beat(KIND_TOGGLE, 4'($urandom), 8'($urandom));
                else if (roll < 78)
                    offer_beat(KIND_REPORT, pool[$urandom_range(0, 2)],
                               near_threshold_quality());
                else if (roll < 84)
                    offer_beat(KIND_SILENCE, 4'($urandom), 8'($urandom));
                else if (roll < 88)
                    offer_beat(KIND_TOGGLE, 4'($urandom), 8'($urandom));
                else if (roll < 91)
                    offer_beat(KIND_SPARE, 4'($urandom), 8'($urandom));
                else if (roll < 94)
                    offer_beat(KIND_REPORT, 4'($urandom), 8'd0);
                else
                    offer_beat(KIND_REPORT, 4'($urandom), 8'($urandom));
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial
    begin
        reset_tracker_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_kinds();
        test_loss_and_recovery();
        test_backpressure();
        test_random_traffic();
        report_valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outcomes_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
